/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the Playfair digraph encryptor.
// Assumes a clock clk_i and an active-low reset rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define PFE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Check that a condition in one cycle implies another in the next cycle
`define PFE_ASSERT_NEXT(label, pre, post) \
  `PFE_ASSERT(label, (pre) |=> (post))

`endif

/* hdl/pfe_pkg.sv */
// Package for the Playfair digraph encryptor: letter codes, mode and register
// codes, the control word type and the microcode program. No dependencies.
package pfe_pkg;

  // Letter codes and square geometry
  localparam logic [4:0] LETTER_I   = 5'd8;
  localparam logic [4:0] LETTER_J   = 5'd9;
  localparam logic [4:0] LETTER_Z   = 5'd25;
  localparam logic [4:0] SPACE_CODE = 5'd26;
  localparam logic [4:0] CELLS      = 5'd25;
  localparam int unsigned NumCells   = 25;
  localparam int unsigned NumLetters = 26;

  // Reset values of the filler registers
  localparam logic [4:0] DOUBLED_RST = 5'd23;
  localparam logic [4:0] END_RST     = 5'd25;

  // Step counter width and step addresses
  localparam int unsigned PcW = 5;
  localparam logic [PcW-1:0] ST_IDLE     = 5'd0;
  localparam logic [PcW-1:0] ST_KEY      = 5'd1;
  localparam logic [PcW-1:0] ST_FIN      = 5'd2;
  localparam logic [PcW-1:0] ST_FIN_DONE = 5'd3;
  localparam logic [PcW-1:0] ST_MSG      = 5'd4;
  localparam logic [PcW-1:0] ST_MSG_BAD  = 5'd5;
  localparam logic [PcW-1:0] ST_MSG_HELD = 5'd6;
  localparam logic [PcW-1:0] ST_MSG_PAIR = 5'd7;
  localparam logic [PcW-1:0] ST_HOLD     = 5'd8;
  localparam logic [PcW-1:0] ST_END      = 5'd9;
  localparam logic [PcW-1:0] ST_END_PAIR = 5'd10;
  localparam logic [PcW-1:0] ST_P_RD_A   = 5'd11;
  localparam logic [PcW-1:0] ST_P_RD_B   = 5'd12;
  localparam logic [PcW-1:0] ST_P_LAT_B  = 5'd13;
  localparam logic [PcW-1:0] ST_P_CALC   = 5'd14;
  localparam logic [PcW-1:0] ST_P_RD_X   = 5'd15;
  localparam logic [PcW-1:0] ST_P_EMIT_X = 5'd16;
  localparam logic [PcW-1:0] ST_P_RD_Y   = 5'd17;
  localparam logic [PcW-1:0] ST_P_EMIT_Y = 5'd18;
  localparam logic [PcW-1:0] ST_SPACE    = 5'd19;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    MODE_KEY    = 2'd0,
    MODE_FINISH = 2'd1,
    MODE_MSG    = 2'd2,
    MODE_END    = 2'd3
  } mode_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_DOUBLED = 1'b0,
    CFG_END     = 1'b1
  } cfg_idx_e;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEXT      = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_SPACE     = 3'd2,
    COND_BAD       = 3'd3,
    COND_NO_HOLD   = 3'd4,
    COND_WALK_MORE = 3'd5
  } cond_e;

  typedef enum logic {
    POS_P1 = 1'b0,
    POS_P2 = 1'b1
  } pos_sel_e;

  typedef enum logic {
    SQ_X = 1'b0,
    SQ_Y = 1'b1
  } sq_sel_e;

  typedef enum logic {
    SRC_SQUARE = 1'b0,
    SRC_SPACE  = 1'b1
  } emit_src_e;

  // One control word of the program
  typedef struct packed {
    cond_e           cond;
    logic [PcW-1:0]  target;
    logic            accept;
    logic            place;
    logic            walk;
    logic            hold;
    logic            pair_msg;
    logic            pair_end;
    pos_sel_e        pos_sel;
    logic            lat_a;
    logic            lat_b;
    logic            calc;
    sq_sel_e         sq_sel;
    logic            emit;
    emit_src_e       emit_src;
    logic            last;
  } ctl_t;

  // Clamp a register letter to z
  function automatic logic [4:0] sat_letter(logic [4:0] v);
    return (v > LETTER_Z) ? LETTER_Z : v;
  endfunction

  // Letter used for square lookup: clamp, then read j as i
  function automatic logic [4:0] lookup_letter(logic [4:0] v);
    logic [4:0] l;
    l = sat_letter(v);
    return (l == LETTER_J) ? LETTER_I : l;
  endfunction

  // Row of a square position
  function automatic logic [2:0] pos_row(logic [4:0] p);
    if (p >= 5'd20) begin
      return 3'd4;
    end else if (p >= 5'd15) begin
      return 3'd3;
    end else if (p >= 5'd10) begin
      return 3'd2;
    end else if (p >= 5'd5) begin
      return 3'd1;
    end
    return 3'd0;
  endfunction

  // Column of a square position
  function automatic logic [2:0] pos_col(logic [4:0] p);
    logic [4:0] r;
    logic [4:0] c;
    r = {2'b00, pos_row(p)};
    c = p - ((r << 2) + r);
    return (c > 5'd4) ? 3'd4 : c[2:0];
  endfunction

  // Step one row or column with wraparound
  function automatic logic [2:0] wrap_inc(logic [2:0] v);
    return (v == 3'd4) ? 3'd0 : v + 3'd1;
  endfunction

  // Position of a row and column
  function automatic logic [4:0] cell_index(logic [2:0] r, logic [2:0] c);
    logic [4:0] rr;
    rr = {2'b00, r};
    return (rr << 2) + rr + {2'b00, c};
  endfunction

  // Entry step for each item kind
  function automatic logic [PcW-1:0] dispatch(logic [1:0] mode);
    logic [PcW-1:0] pc;
    unique case (mode)
      MODE_KEY:    pc = ST_KEY;
      MODE_FINISH: pc = ST_FIN;
      MODE_MSG:    pc = ST_MSG;
      MODE_END:    pc = ST_END;
      default:     pc = ST_IDLE;
    endcase
    return pc;
  endfunction

  // Microcode program
  function automatic ctl_t ucode(logic [PcW-1:0] pc);
    ctl_t c;
    c = '0;
    unique case (pc)
      ST_IDLE: begin
        c.accept = 1'b1;
      end
      ST_KEY: begin
        c.place  = 1'b1;
        c.cond   = COND_ALWAYS;
        c.target = ST_IDLE;
      end
      ST_FIN: begin
        c.place  = 1'b1;
        c.walk   = 1'b1;
        c.cond   = COND_WALK_MORE;
        c.target = ST_FIN;
      end
      ST_FIN_DONE: begin
        c.cond   = COND_ALWAYS;
        c.target = ST_IDLE;
      end
      ST_MSG: begin
        c.cond   = COND_SPACE;
        c.target = ST_SPACE;
      end
      ST_MSG_BAD: begin
        c.cond   = COND_BAD;
        c.target = ST_IDLE;
      end
      ST_MSG_HELD: begin
        c.cond   = COND_NO_HOLD;
        c.target = ST_HOLD;
      end
      ST_MSG_PAIR: begin
        c.pair_msg = 1'b1;
        c.cond     = COND_ALWAYS;
        c.target   = ST_P_RD_A;
      end
      ST_HOLD: begin
        c.hold   = 1'b1;
        c.cond   = COND_ALWAYS;
        c.target = ST_IDLE;
      end
      ST_END: begin
        c.cond   = COND_NO_HOLD;
        c.target = ST_IDLE;
      end
      ST_END_PAIR: begin
        c.pair_end = 1'b1;
        c.cond     = COND_ALWAYS;
        c.target   = ST_P_RD_A;
      end
      ST_P_RD_A: begin
        c.pos_sel = POS_P1;
      end
      ST_P_RD_B: begin
        c.pos_sel = POS_P2;
        c.lat_a   = 1'b1;
      end
      ST_P_LAT_B: begin
        c.lat_b = 1'b1;
      end
      ST_P_CALC: begin
        c.calc = 1'b1;
      end
      ST_P_RD_X: begin
        c.sq_sel = SQ_X;
      end
      ST_P_EMIT_X: begin
        c.sq_sel = SQ_X;
        c.emit   = 1'b1;
      end
      ST_P_RD_Y: begin
        c.sq_sel = SQ_Y;
      end
      ST_P_EMIT_Y: begin
        c.sq_sel = SQ_Y;
        c.emit   = 1'b1;
        c.last   = 1'b1;
        c.cond   = COND_ALWAYS;
        c.target = ST_IDLE;
      end
      ST_SPACE: begin
        c.emit     = 1'b1;
        c.emit_src = SRC_SPACE;
        c.last     = 1'b1;
        c.cond     = COND_ALWAYS;
        c.target   = ST_IDLE;
      end
      default: begin
        c.cond   = COND_ALWAYS;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

/* hdl/playfair_digraph_encryptor.sv */
// Channel    | Dir | Beat contents
// s_axis     | in  | tdata[4:0] symbol, tuser[1:0] mode
// m_axis     | out | tdata[4:0] out_symbol, tlast last
// cfg        | in  | cfg_idx_i register index, cfg_wdata_i[4:0] value
//
// One sequencer step per cycle. Finish is a walk over the alphabet. The letter pair
// of a message or of the end of message takes two reads each from the single-port
// position and square RAMs. A result step stalls while the output register is full
// and not taken. Reset clears the key state; no clearing pass.
// Depends on pfe_pkg, pfe_ram and assert_macros.svh.
module playfair_digraph_encryptor (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [4:0] symbol, [7:5] zero
  input  logic [1:0] s_axis_tuser,   // [1:0] mode
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [4:0] out_symbol, [7:5] zero
  output logic       m_axis_tlast,
  // configuration writes
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [4:0] cfg_wdata_i
);

  logic [pfe_pkg::PcW-1:0] pc_q, pc_d;
  pfe_pkg::ctl_t           ctl;

  logic [4:0]  doubled_q, end_q;
  logic [4:0]  letter_q;
  logic [25:0] used_q;
  logic [4:0]  fill_q;
  logic [4:0]  held_q;
  logic        held_valid_q;
  logic [4:0]  p1_q, p2_q;
  logic [4:0]  pos_a_q, pos_b_q;
  logic [4:0]  x_q, y_q;
  logic        m_valid_q;
  logic [4:0]  m_sym_q;
  logic        m_last_q;

  logic        accept;
  logic        out_free;
  logic        stall;
  logic        cond_hit;
  logic        used_bit;
  logic        place_ok;
  logic [4:0]  pos_addr, pos_rdata;
  logic [4:0]  sq_addr, sq_rdata;
  logic [4:0]  end_pick;
  logic [2:0]  r1, c1, r2, c2;
  logic [4:0]  x_d, y_d;

  // Decode the current step
  assign ctl           = pfe_pkg::ucode(pc_q);
  assign s_axis_tready = ctl.accept;
  assign accept        = s_axis_tvalid && ctl.accept;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign stall         = ctl.emit && !out_free;

  // Evaluate the jump condition
  always_comb begin
    case (ctl.cond)
      pfe_pkg::COND_NEXT:      cond_hit = 1'b0;
      pfe_pkg::COND_ALWAYS:    cond_hit = 1'b1;
      pfe_pkg::COND_SPACE:     cond_hit = (letter_q == pfe_pkg::SPACE_CODE);
      pfe_pkg::COND_BAD:       cond_hit = (letter_q > pfe_pkg::SPACE_CODE);
      pfe_pkg::COND_NO_HOLD:   cond_hit = !held_valid_q;
      pfe_pkg::COND_WALK_MORE: cond_hit = (letter_q != pfe_pkg::LETTER_Z);
      default:                 cond_hit = 1'b1;
    endcase
  end

  // Advance the step counter
  always_comb begin
    if (ctl.accept) begin
      pc_d = accept ? pfe_pkg::dispatch(s_axis_tuser) : pc_q;
    end else if (stall) begin
      pc_d = pc_q;
    end else if (cond_hit) begin
      pc_d = ctl.target;
    end else begin
      pc_d = pc_q + 5'd1;
    end
  end

  // Place a letter into the square if it is new and there is room
  assign used_bit = (letter_q <= pfe_pkg::LETTER_Z) ? used_q[letter_q] : 1'b1;
  assign place_ok = ctl.place && (fill_q < pfe_pkg::CELLS) && !used_bit;

  // Second letter at end of message
  always_comb begin
    end_pick = pfe_pkg::sat_letter(end_q);
    if (end_pick == held_q) begin
      end_pick = pfe_pkg::sat_letter(doubled_q);
    end
  end

  // Cipher positions from the two square positions
  assign r1 = pfe_pkg::pos_row(pos_a_q);
  assign c1 = pfe_pkg::pos_col(pos_a_q);
  assign r2 = pfe_pkg::pos_row(pos_b_q);
  assign c2 = pfe_pkg::pos_col(pos_b_q);

  always_comb begin
    if (r1 == r2) begin
      x_d = pfe_pkg::cell_index(r1, pfe_pkg::wrap_inc(c1));
      y_d = pfe_pkg::cell_index(r2, pfe_pkg::wrap_inc(c2));
    end else if (c1 == c2) begin
      x_d = pfe_pkg::cell_index(pfe_pkg::wrap_inc(r1), c1);
      y_d = pfe_pkg::cell_index(pfe_pkg::wrap_inc(r2), c2);
    end else begin
      x_d = pfe_pkg::cell_index(r1, c2);
      y_d = pfe_pkg::cell_index(r2, c1);
    end
  end

  // RAM address selection
  assign pos_addr = ctl.place ? letter_q :
                    ((ctl.pos_sel == pfe_pkg::POS_P2) ? p2_q : p1_q);
  assign sq_addr  = ctl.place ? fill_q :
                    ((ctl.sq_sel == pfe_pkg::SQ_Y) ? y_q : x_q);

  pfe_ram #(
    .Width (5),
    .Depth (pfe_pkg::NumLetters)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (place_ok),
    .addr_i  (pos_addr),
    .wdata_i (fill_q),
    .rdata_o (pos_rdata)
  );

  pfe_ram #(
    .Width (5),
    .Depth (pfe_pkg::NumCells)
  ) u_square_ram (
    .clk_i   (clk_i),
    .we_i    (place_ok),
    .addr_i  (sq_addr),
    .wdata_i (letter_q),
    .rdata_o (sq_rdata)
  );

  // Control state: step counter, fillers, key bookkeeping, hold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= pfe_pkg::ST_IDLE;
      doubled_q    <= pfe_pkg::DOUBLED_RST;
      end_q        <= pfe_pkg::END_RST;
      used_q       <= 26'(1) << pfe_pkg::LETTER_J;
      fill_q       <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pfe_pkg::CFG_DOUBLED: doubled_q <= cfg_wdata_i;
          pfe_pkg::CFG_END:     end_q     <= cfg_wdata_i;
          default:              ;
        endcase
      end
      if (place_ok) begin
        used_q[letter_q] <= 1'b1;
        fill_q           <= fill_q + 5'd1;
      end
      if (ctl.hold) begin
        held_q       <= letter_q;
        held_valid_q <= 1'b1;
      end else if (ctl.pair_msg && (letter_q != held_q)) begin
        held_valid_q <= 1'b0;
      end else if (ctl.pair_end) begin
        held_valid_q <= 1'b0;
      end
      if (ctl.emit && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      letter_q <= (s_axis_tuser == pfe_pkg::MODE_FINISH) ? 5'd0 : s_axis_tdata[4:0];
    end else if (ctl.walk) begin
      letter_q <= letter_q + 5'd1;
    end
    if (ctl.pair_msg) begin
      p1_q <= pfe_pkg::lookup_letter(held_q);
      p2_q <= (letter_q == held_q) ? pfe_pkg::lookup_letter(doubled_q)
                                   : pfe_pkg::lookup_letter(letter_q);
    end else if (ctl.pair_end) begin
      p1_q <= pfe_pkg::lookup_letter(held_q);
      p2_q <= pfe_pkg::lookup_letter(end_pick);
    end
    if (ctl.lat_a) begin
      pos_a_q <= pos_rdata;
    end
    if (ctl.lat_b) begin
      pos_b_q <= pos_rdata;
    end
    if (ctl.calc) begin
      x_q <= x_d;
      y_q <= y_d;
    end
    if (ctl.emit && out_free) begin
      m_sym_q  <= (ctl.emit_src == pfe_pkg::SRC_SPACE) ? pfe_pkg::SPACE_CODE : sq_rdata;
      m_last_q <= ctl.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_sym_q};
  assign m_axis_tlast  = m_last_q;

`include "assert_macros.svh"

  `PFE_ASSERT(a_fill_range, fill_q <= pfe_pkg::CELLS)
  `PFE_ASSERT(a_j_never_free, used_q[pfe_pkg::LETTER_J])
  `PFE_ASSERT(a_held_letter, !held_valid_q || (held_q <= pfe_pkg::LETTER_Z))
  `PFE_ASSERT_NEXT(a_stall_holds_step, ctl.emit && m_valid_q && !m_axis_tready, $stable(pc_q))

endmodule

/* hdl/pfe_ram.sv */
// Generic single-port RAM with registered read for the Playfair encryptor.
// No dependencies.
module pfe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write on enable, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
